### sv/sjf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared constants and types of the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

	localparam int MAX_JOBS = 32;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int ID_W     = 16;
	localparam int BURST_W  = 16;
	localparam int SUM_W    = 22;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 80;

	// One slot of the sorting chain.
	typedef struct packed {
		logic               valid;
		logic [BURST_W-1:0] burst;
		logic [ID_W-1:0]    id;
	} entry_t;

	// Chain command, shared by all cells.
	typedef struct packed {
		logic insert;
		logic drain;
	} ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

### sv/sjf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_cell
// One slot of the insertion chain: keeps, takes the new job, or shifts.
// ----------------------------------------------------------------------------
module sjf_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sjf_pkg::ctl_t                   ctl,
	input  logic [sjf_pkg::BURST_W-1:0]     new_burst,
	input  logic [sjf_pkg::ID_W-1:0]        new_id,
	input  sjf_pkg::entry_t                 left,
	input  logic                            left_keep,
	input  sjf_pkg::entry_t                 right,
	output sjf_pkg::entry_t                 ent,
	output logic                            keep
);

	sjf_pkg::entry_t ent_q;
	sjf_pkg::entry_t ent_d;

	// Equal bursts stay ahead of the new job, which keeps the order stable.
	assign keep = ent_q.valid && (ent_q.burst <= new_burst);
	assign ent  = ent_q;

	always_comb begin
		ent_d = ent_q;
		if (ctl.drain) begin
			ent_d = right;
		end else if (ctl.insert && !keep) begin
			if (left_keep) begin
				ent_d.valid = 1'b1;
				ent_d.burst = new_burst;
				ent_d.id    = new_id;
			end else begin
				ent_d = left;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

### sv/sjf_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_out
// Result register with the running elapsed-time accumulator.
// ----------------------------------------------------------------------------
module sjf_out (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req,
	input  sjf_pkg::entry_t               head,
	input  logic                          dropped,
	input  logic                          last,
	output logic                          pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [sjf_pkg::OUT_W-1:0]     m_axis_tdata,
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);

	logic                      valid_q;
	logic [sjf_pkg::SUM_W-1:0] elapsed_q;
	logic [sjf_pkg::SUM_W-1:0] finish;
	logic [sjf_pkg::ID_W-1:0]  id_q;
	logic [sjf_pkg::BURST_W-1:0] burst_q;
	logic [sjf_pkg::SUM_W-1:0] wait_q;
	logic [sjf_pkg::SUM_W-1:0] finish_q;
	logic                      ovf_q;
	logic                      last_q;

	assign pop    = req && (!valid_q || m_axis_tready);
	assign finish = elapsed_q + sjf_pkg::SUM_W'(head.burst);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			elapsed_q <= '0;
		end else begin
			if (pop) begin
				valid_q   <= 1'b1;
				elapsed_q <= last ? '0 : finish;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			id_q     <= head.id;
			burst_q  <= head.burst;
			wait_q   <= elapsed_q;
			finish_q <= finish;
			ovf_q    <= dropped;
			last_q   <= last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {4'b0000, finish_q, wait_q, burst_q, id_q};
	assign m_axis_tuser  = ovf_q;
	assign m_axis_tlast  = last_q;

endmodule

### sv/shortest_job_first_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_job_first_scheduler_top
// Non-preemptive shortest-job-first scheduler over a batch of jobs.
// ----------------------------------------------------------------------------
// Usage: jobs arrive on the s_axis request channel, one per cycle, with the
// identifier and burst length in tdata and tlast marking the final job of a
// batch. Each accepted job is placed at once into a chain of MAX_JOBS cells
// that always holds the jobs sorted by burst, equal bursts in arrival order.
// A job that arrives while the chain is full is dropped and the batch is
// flagged; the flag appears in tuser of every result of that batch.
// After the tlast request the block stops taking requests and drains the
// chain, one result per cycle on m_axis while the receiver is ready:
// identifier, burst, wait time and finish time, with tlast on the final
// result. Accepting the tlast request moves the block to draining, and the
// first pop then loads the result register. Draining is paced by the
// single result register at the head of the chain, which moves only when
// the receiver takes the result or the register is empty. A stalled
// receiver freezes the chain with nothing lost. Reset empties the chain,
// clears the overflow flag and returns the block to loading; no clearing
// pass is needed, so requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module shortest_job_first_scheduler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [sjf_pkg::IN_W-1:0]      s_axis_tdata,  // job_id, burst_length
	input  logic                          s_axis_tlast,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [sjf_pkg::OUT_W-1:0]     m_axis_tdata,  // out_job_id, out_burst,
	                                                     // wait_time, finish_time, pad
	output logic                          m_axis_tuser,  // overflow_flag
	output logic                          m_axis_tlast
);

	sjf_pkg::state_t               state_q;
	logic [sjf_pkg::CNT_W-1:0]     count_q;
	logic                          dropped_q;
	logic                          accept;
	logic                          full;
	logic                          pop;
	logic                          last_out;
	sjf_pkg::ctl_t                 ctl;
	logic [sjf_pkg::ID_W-1:0]      new_id;
	logic [sjf_pkg::BURST_W-1:0]   new_burst;
	sjf_pkg::entry_t               ents [sjf_pkg::MAX_JOBS];
	logic [sjf_pkg::MAX_JOBS-1:0]  keeps;
	logic [sjf_pkg::MAX_JOBS-1:0]  valids;

	assign new_id    = s_axis_tdata[sjf_pkg::ID_W-1:0];
	assign new_burst = s_axis_tdata[sjf_pkg::ID_W +: sjf_pkg::BURST_W];

	assign s_axis_tready = (state_q == sjf_pkg::ST_LOAD);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (count_q == sjf_pkg::CNT_W'(sjf_pkg::MAX_JOBS));
	assign last_out      = (count_q == sjf_pkg::CNT_W'(1));

	// The chain either takes the new job or shifts toward the output.
	assign ctl.insert = accept && !full;
	assign ctl.drain  = pop;

	genvar gi;
	generate
		for (gi = 0; gi < sjf_pkg::MAX_JOBS; gi++) begin : g_cell
			sjf_pkg::entry_t left_ent;
			sjf_pkg::entry_t right_ent;
			logic            left_keep;

			if (gi == 0) begin : g_first
				assign left_ent  = '0;
				assign left_keep = 1'b1;
			end else begin : g_mid
				assign left_ent  = ents[gi-1];
				assign left_keep = keeps[gi-1];
			end

			if (gi == sjf_pkg::MAX_JOBS - 1) begin : g_end
				assign right_ent = '0;
			end else begin : g_inner
				assign right_ent = ents[gi+1];
			end

			sjf_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.new_burst (new_burst),
				.new_id    (new_id),
				.left      (left_ent),
				.left_keep (left_keep),
				.right     (right_ent),
				.ent       (ents[gi]),
				.keep      (keeps[gi])
			);

			assign valids[gi] = ents[gi].valid;
		end
	endgenerate

	sjf_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (state_q == sjf_pkg::ST_DRAIN),
		.head          (ents[0]),
		.dropped       (dropped_q),
		.last          (last_out),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Load until the final job, then drain until the count runs out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sjf_pkg::ST_LOAD;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				sjf_pkg::ST_LOAD: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= sjf_pkg::ST_DRAIN;
						end
					end
				end
				sjf_pkg::ST_DRAIN: begin
					if (pop) begin
						count_q <= count_q - 1'b1;
						if (last_out) begin
							state_q   <= sjf_pkg::ST_LOAD;
							dropped_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= sjf_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// The count never passes the chain length.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sjf_pkg::CNT_W'(sjf_pkg::MAX_JOBS))
		else $error("job count beyond chain length");

	// The occupied cells always match the job count.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == 32'(count_q))
		else $error("chain occupancy differs from job count");

	// The head pair of the chain stays in ascending burst order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		ents[1].valid |-> (ents[0].valid && ents[0].burst <= ents[1].burst))
		else $error("chain head out of order");

	// Taking the final result empties the chain and reopens loading.
	a_batch_done: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && last_out) |=> (state_q == sjf_pkg::ST_LOAD && valids == '0 && !dropped_q))
		else $error("chain not empty after final result");

	// Nothing drains while loading.
	a_no_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sjf_pkg::ST_LOAD) |-> !pop)
		else $error("drain while loading");

endmodule

### verif/sjf_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjf_schedule_checker
// Watches both stream channels of the shortest-job-first scheduler, predicts
// the schedule of every batch and compares each result field by field.
// ----------------------------------------------------------------------------
module sjf_schedule_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	input  logic [sjf_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                      s_axis_tlast,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	input  logic [sjf_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                      m_axis_tuser,
	input  logic                      m_axis_tlast,
	output int                        fail_count,
	output int                        pending,
	output int                        checked
);

	localparam int ID_W      = sjf_pkg::ID_W;
	localparam int BURST_W   = sjf_pkg::BURST_W;
	localparam int SUM_W     = sjf_pkg::SUM_W;
	localparam int OUT_W     = sjf_pkg::OUT_W;
	localparam int MAX_JOBS  = sjf_pkg::MAX_JOBS;
	localparam int BURST_LO  = ID_W;
	localparam int WAIT_LO   = ID_W + BURST_W;
	localparam int FINISH_LO = WAIT_LO + SUM_W;
	localparam int PAD_LO    = FINISH_LO + SUM_W;

	typedef struct {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
	} job_t;

	typedef struct {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [SUM_W-1:0]   wait_time;
		logic [SUM_W-1:0]   finish_time;
		logic               overflow;
		logic               last;
	} slot_t;

	job_t  held_jobs[$];
	logic  overflow_seen;
	slot_t schedule_q[$];
	int    errors;
	int    results_seen;

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		$display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
			$realtime, results_seen, what, want, got);
		errors++;
	endtask

	// Stable order by burst: a job goes behind every job with a burst not
	// larger than its own, so equal bursts keep their arrival order.
	task automatic schedule_batch();
		job_t             sorted[$];
		int               pos;
		logic [SUM_W-1:0] elapsed;
		slot_t            slot;

		elapsed = '0;
		foreach (held_jobs[k]) begin
			pos = sorted.size();
			while (pos > 0 && sorted[pos-1].burst > held_jobs[k].burst)
				pos--;
			sorted.insert(pos, held_jobs[k]);
		end
		foreach (sorted[k]) begin
			slot.id          = sorted[k].id;
			slot.burst       = sorted[k].burst;
			slot.wait_time   = elapsed;
			slot.finish_time = elapsed + SUM_W'(sorted[k].burst);
			slot.overflow    = overflow_seen;
			slot.last        = (k == sorted.size() - 1);
			schedule_q.push_back(slot);
			elapsed = slot.finish_time;
		end
		held_jobs.delete();
		overflow_seen = 1'b0;
	endtask

	task automatic check_result();
		slot_t want;

		if (schedule_q.size() == 0) begin
			report_mismatch("result with nothing scheduled, job id", 0,
				m_axis_tdata[ID_W-1:0]);
		end else begin
			want = schedule_q.pop_front();
			if (m_axis_tdata[ID_W-1:0] !== want.id)
				report_mismatch("job id", want.id, m_axis_tdata[ID_W-1:0]);
			if (m_axis_tdata[BURST_LO +: BURST_W] !== want.burst)
				report_mismatch("burst", want.burst, m_axis_tdata[BURST_LO +: BURST_W]);
			if (m_axis_tdata[WAIT_LO +: SUM_W] !== want.wait_time)
				report_mismatch("wait time", want.wait_time,
					m_axis_tdata[WAIT_LO +: SUM_W]);
			if (m_axis_tdata[FINISH_LO +: SUM_W] !== want.finish_time)
				report_mismatch("finish time", want.finish_time,
					m_axis_tdata[FINISH_LO +: SUM_W]);
			if (m_axis_tdata[OUT_W-1:PAD_LO] !== '0)
				report_mismatch("padding", 0, m_axis_tdata[OUT_W-1:PAD_LO]);
			if (m_axis_tuser !== want.overflow)
				report_mismatch("overflow flag", want.overflow, m_axis_tuser);
			if (m_axis_tlast !== want.last)
				report_mismatch("last flag", want.last, m_axis_tlast);
		end
		results_seen++;
	endtask

	// Outputs are updated with nonblocking assignments so the top reads
	// settled values at the following edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_jobs.delete();
			schedule_q.delete();
			overflow_seen = 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready) begin
				if (held_jobs.size() < MAX_JOBS)
					held_jobs.push_back('{s_axis_tdata[ID_W-1:0],
						s_axis_tdata[BURST_LO +: BURST_W]});
				else
					overflow_seen = 1'b1;
				if (s_axis_tlast)
					schedule_batch();
			end
		end
		pending    <= schedule_q.size();
		fail_count <= errors;
		checked    <= results_seen;
	end

endmodule

### verif/tb_shortest_job_first_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_job_first_scheduler_top
// Drives batches of jobs into the scheduler and gives the verdict; the
// checker beside the block predicts each schedule and compares results.
// ----------------------------------------------------------------------------
module tb_shortest_job_first_scheduler_top;

	localparam int ID_W     = sjf_pkg::ID_W;
	localparam int BURST_W  = sjf_pkg::BURST_W;
	localparam int IN_W     = sjf_pkg::IN_W;
	localparam int OUT_W    = sjf_pkg::OUT_W;
	localparam int MAX_JOBS = sjf_pkg::MAX_JOBS;

	// Generous bound: a few hundred jobs with sender gaps, each result
	// possibly held by a long receiver stall, is well under this.
	localparam int CYCLE_LIMIT = 200000;
	localparam int JOB_TARGET  = 260;

	// How the burst lengths of one batch are drawn.
	typedef enum int {
		MIX_FULL,      // anywhere in the 16-bit range
		MIX_TIES,      // a handful of values, so equal bursts are common
		MIX_EXTREMES,  // only the ends of the range
		MIX_MAX        // every burst at its largest, for the largest sums
	} burst_mix_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;   // job_id, burst_length
	logic             s_axis_tlast = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // out_job_id, out_burst, wait_time,
	                                       // finish_time, pad
	logic             m_axis_tuser;        // overflow_flag
	logic             m_axis_tlast;

	int fail_count;
	int pending;
	int checked;

	int jobs_sent;
	int batches_sent;
	int overflow_batches;
	int burst_left;
	int cycles;

	always #5 clk = ~clk;

	shortest_job_first_scheduler_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	sjf_schedule_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked)
	);

	// Sends one job request. The sender works in bursts: when a burst is
	// used up, valid drops for a random gap (sometimes none at all) with
	// junk on the data lines, then a new burst of random length starts.
	// Valid is never lowered and raised in the same step, so back-to-back
	// requests keep it high across the handshake.
	task automatic send_job(input logic [ID_W-1:0] id, input logic [BURST_W-1:0] burst,
			input logic last);
		int gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				s_axis_tdata  <= $urandom;
				s_axis_tlast  <= 1'($urandom_range(0, 1));
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {burst, id};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		jobs_sent++;
	endtask

	function automatic logic [BURST_W-1:0] pick_burst(input burst_mix_t mix);
		case (mix)
			MIX_TIES: return BURST_W'($urandom_range(0, 7));
			MIX_EXTREMES: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return BURST_W'(1);
					2: return {{(BURST_W-1){1'b1}}, 1'b0};
					default: return '1;
				endcase
			end
			MIX_MAX: return '1;
			default: return BURST_W'($urandom);
		endcase
	endfunction

	// A batch of random identifiers; only the final job carries tlast.
	// Batches larger than the store end with a dropped job, tlast included.
	task automatic send_batch(input int count, input burst_mix_t mix);
		for (int k = 0; k < count; k++)
			send_job(ID_W'($urandom), pick_burst(mix), k == count - 1);
		batches_sent++;
		if (count > MAX_JOBS)
			overflow_batches++;
	endtask

	// The receiver changes its manner every so often: always ready, mostly
	// ready, or stalling for long stretches with rare acceptances.
	int stall_mode;
	int mode_left;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode = 0;
			mode_left  = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(8, 80);
			end
			mode_left--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycles, pending);
			$display("** shortest_job_first_scheduler_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int         size_pick;
		int         count;
		burst_mix_t mix;

		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Single-job batches at both ends of the fields.
		send_job('0, '0, 1'b1);
		batches_sent++;
		send_job('1, '1, 1'b1);
		batches_sent++;
		// Out of order with ties, zero and the largest burst mixed in;
		// equal bursts must leave in arrival order.
		send_job(16'h0001, 16'h0005, 1'b0);
		send_job(16'h0002, 16'h0005, 1'b0);
		send_job(16'h0003, 16'h0003, 1'b0);
		send_job('1,       '1,       1'b0);
		send_job(16'h0005, '0,       1'b0);
		send_job(16'h0006, 16'h0003, 1'b1);
		batches_sent++;
		// Equal bursts already in order.
		send_job(16'h8000, 16'h0007, 1'b0);
		send_job(16'h7FFF, 16'h0007, 1'b1);
		batches_sent++;

		// A full store plus dropped jobs at the largest burst gives the
		// largest wait and finish times and the overflow flag; then a
		// store filled exactly to capacity, which must not be flagged.
		send_batch(MAX_JOBS + 2, MIX_MAX);
		send_batch(MAX_JOBS, MIX_FULL);

		// Random part: mostly short batches, with a share of long, exactly
		// full and overflowing ones, and varied burst distributions.
		while (jobs_sent < JOB_TARGET) begin
			size_pick = $urandom_range(0, 99);
			if (size_pick < 65)
				count = $urandom_range(1, 8);
			else if (size_pick < 80)
				count = $urandom_range(9, MAX_JOBS - 1);
			else if (size_pick < 90)
				count = MAX_JOBS;
			else
				count = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
			mix = burst_mix_t'($urandom_range(0, 2));
			send_batch(count, mix);
		end
		s_axis_tvalid <= 1'b0;

		// Drain: the checker's count is registered, so poll from the
		// next edge on, then give the block time to show any stray result.
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);

		$display("Sent %0d jobs in %0d batches, %0d of them over capacity.",
			jobs_sent, batches_sent, overflow_batches);
		$display("Checked %0d scheduled results under random sender gaps and receiver stalls.",
			checked);
		if (fail_count == 0) begin
			$display("** shortest_job_first_scheduler_top: PASSED **");
		end else begin
			$display("** shortest_job_first_scheduler_top: FAILED **");
		end
		$finish;
	end

endmodule

### sim.f
sv/sjf_pkg.sv
sv/sjf_cell.sv
sv/sjf_out.sv
sv/shortest_job_first_scheduler_top.sv
verif/sjf_schedule_checker.sv
verif/tb_shortest_job_first_scheduler_top.sv
